@@ sv/rrp_pkg.sv @@
// ============================================================================
// rrp_pkg
// Shared constants, types and register codes of the Rademacher projection.
// ============================================================================
package rrp_pkg;

    localparam int IN_DIM  = 5;
    localparam int OUT_DIM = 3;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 20;
    localparam int SUM_W    = ACC_W + 1;
    localparam int SCALE_W  = 16;
    localparam int PROD_W   = ACC_W + SCALE_W;
    localparam int OUT_W    = 20;
    localparam int IDX_W    = 3;
    localparam int SIGN_W   = 64;
    localparam int SIGN_IDX_W = 6;
    localparam int POS_W    = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int ROW_W    = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;

    localparam int ACC_MAX = 524287;
    localparam int ACC_MIN = -524288;
    localparam int OUT_MAX = 262144;
    localparam int ROUND_HALF = 16384;
    localparam int FRAC_BITS  = 15;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd18919;

    // Configuration bus.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;
    localparam logic REG_SIGN_BITS = 1'b0;
    localparam logic REG_SCALE_Q   = 1'b1;

    // Snapshot queue.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef acc_t [OUT_DIM-1:0] snap_t;

    typedef struct packed {
        logic [SIGN_W-1:0]  sign_bits;
        logic [SCALE_W-1:0] scale_q;
    } cfg_t;

    typedef struct packed {
        logic  push;
        snap_t data;
    } q_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ sv/rrp_if.sv @@
// ============================================================================
// rrp_if
// Valid/ready channels for input elements and for projected coordinates.
// ============================================================================
interface rrp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rrp_pkg::SAMPLE_W-1:0]  sample;
    logic                                 vector_end;

    modport source (output valid, output sample, output vector_end, input ready);
    modport sink   (input valid, input sample, input vector_end, output ready);
endinterface

interface rrp_out_if;
    logic                               valid;
    logic                               ready;
    logic [rrp_pkg::IDX_W-1:0]          coord_index;
    logic signed [rrp_pkg::OUT_W-1:0]   projected;
    logic                               final_coord;

    modport source (output valid, output coord_index, output projected,
                    output final_coord, input ready);
    modport sink   (input valid, input coord_index, input projected,
                    input final_coord, output ready);
endinterface

@@ sv/rrp_cfg.sv @@
// ============================================================================
// rrp_cfg
// APB register file holding the sign matrix and the output scale.
// ============================================================================
module rrp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rrp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rrp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output rrp_pkg::cfg_t                    cfg
);

    logic [rrp_pkg::SIGN_W-1:0]  sign_bits_reg;
    logic [rrp_pkg::SCALE_W-1:0] scale_q_reg;
    logic                        wr_en;
    logic                        reg_sel;

    assign pready  = 1'b1;
    // Registers sit on 8-byte boundaries, so bit 3 picks the register.
    assign reg_sel = paddr[3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_bits_reg <= '0;
            scale_q_reg   <= rrp_pkg::SCALE_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == rrp_pkg::REG_SIGN_BITS)
            begin
                sign_bits_reg <= pwdata;
            end
            else
            begin
                scale_q_reg <= pwdata[rrp_pkg::SCALE_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            rrp_pkg::REG_SIGN_BITS: prdata = sign_bits_reg;
            rrp_pkg::REG_SCALE_Q:
                prdata = {{(rrp_pkg::CFG_DATA_W-rrp_pkg::SCALE_W){1'b0}}, scale_q_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.sign_bits = sign_bits_reg;
    assign cfg.scale_q   = scale_q_reg;

endmodule

@@ sv/rrp_front.sv @@
// ============================================================================
// rrp_front
// Accepts elements and updates every accumulator in parallel; a vector's
// final element hands the finished sums to the queue and clears them.
// ============================================================================
module rrp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    rrp_in_if.sink                           sample_ch,
    input  logic [rrp_pkg::SIGN_W-1:0]       sign_bits,
    input  rrp_pkg::q_stat_t                 q_stat,
    output rrp_pkg::q_wr_t                   q_wr
);

    logic [rrp_pkg::POS_W-1:0] pos_reg;
    logic [rrp_pkg::POS_W-1:0] pos_next;
    rrp_pkg::snap_t            acc_reg;
    rrp_pkg::snap_t            acc_next;
    rrp_pkg::snap_t            acc_upd;
    logic                      accept;

    // A whole word is taken only while a queue slot is free for its sums.
    assign sample_ch.ready = !q_stat.full;
    assign accept          = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        logic [rrp_pkg::SIGN_IDX_W-1:0] bit_idx;
        logic signed [rrp_pkg::SUM_W-1:0] smp;
        logic signed [rrp_pkg::SUM_W-1:0] sum;
        smp = rrp_pkg::SUM_W'(sample_ch.sample);
        for (int r = 0; r < rrp_pkg::OUT_DIM; r++)
        begin
            bit_idx = rrp_pkg::SIGN_IDX_W'(r * rrp_pkg::IN_DIM)
                    + rrp_pkg::SIGN_IDX_W'(pos_reg);
            if (sign_bits[bit_idx])
            begin
                sum = rrp_pkg::SUM_W'(acc_reg[r]) + smp;
            end
            else
            begin
                sum = rrp_pkg::SUM_W'(acc_reg[r]) - smp;
            end
            if (sum > rrp_pkg::SUM_W'(rrp_pkg::ACC_MAX))
            begin
                acc_upd[r] = rrp_pkg::ACC_W'(rrp_pkg::ACC_MAX);
            end
            else if (sum < rrp_pkg::SUM_W'(rrp_pkg::ACC_MIN))
            begin
                acc_upd[r] = rrp_pkg::ACC_W'(rrp_pkg::ACC_MIN);
            end
            else
            begin
                acc_upd[r] = sum[rrp_pkg::ACC_W-1:0];
            end
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            if (sample_ch.vector_end)
            begin
                acc_next = '0;
                pos_next = '0;
            end
            else
            begin
                acc_next = acc_upd;
                // Longer vectors wrap round to the first column.
                if (32'(pos_reg) + 1 >= rrp_pkg::IN_DIM)
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
        end
    end

    assign q_wr.push = accept && sample_ch.vector_end;
    assign q_wr.data = acc_upd;

endmodule

@@ sv/rrp_queue.sv @@
// ============================================================================
// rrp_queue
// Two-entry queue of finished accumulator sets between front and back.
// ============================================================================
module rrp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrp_pkg::q_wr_t       q_wr,
    input  logic                 pop,
    output rrp_pkg::q_stat_t     q_stat,
    output rrp_pkg::snap_t       head
);

    rrp_pkg::snap_t               slot_reg [rrp_pkg::QDEPTH];
    logic [rrp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rrp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rrp_pkg::QCNT_W-1:0]   cnt_reg;
    logic [rrp_pkg::QCNT_W-1:0]   cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign q_stat.full  = (cnt_reg == rrp_pkg::QCNT_W'(rrp_pkg::QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = q_wr.push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= q_wr.data;
        end
    end

endmodule

@@ sv/rrp_back.sv @@
// ============================================================================
// rrp_back
// Walks queued sums one coordinate a cycle, unless the output stalls, through
// a magnitude, multiply and round/saturate pipeline into the output register.
// ============================================================================
module rrp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rrp_pkg::SCALE_W-1:0]   scale_q,
    input  rrp_pkg::q_stat_t              q_stat,
    input  rrp_pkg::snap_t                head,
    output logic                          pop,
    rrp_out_if.source                     result_ch
);

    localparam logic [rrp_pkg::ROW_W-1:0] LAST_ROW = rrp_pkg::ROW_W'(rrp_pkg::OUT_DIM - 1);

    logic [rrp_pkg::ROW_W-1:0]   row_reg;
    logic                        adv;
    logic                        issue;
    rrp_pkg::acc_t               sel_acc;

    logic                        s1_valid_reg;
    logic [rrp_pkg::ACC_W-1:0]   s1_mag_reg;
    logic                        s1_neg_reg;
    logic [rrp_pkg::ROW_W-1:0]   s1_row_reg;
    logic                        s1_last_reg;

    logic                        s2_valid_reg;
    logic [rrp_pkg::PROD_W-1:0]  s2_prod_reg;
    logic                        s2_neg_reg;
    logic [rrp_pkg::ROW_W-1:0]   s2_row_reg;
    logic                        s2_last_reg;

    logic                        out_valid_reg;
    logic [rrp_pkg::IDX_W-1:0]   out_idx_reg;
    logic signed [rrp_pkg::OUT_W-1:0] out_val_reg;
    logic                        out_last_reg;
    logic signed [rrp_pkg::OUT_W-1:0] out_val_next;

    // The whole pipeline moves together whenever the output slot frees up.
    assign adv     = !out_valid_reg || result_ch.ready;
    assign issue   = adv && !q_stat.empty;
    assign pop     = issue && (row_reg == LAST_ROW);
    assign sel_acc = head[row_reg];

    always_comb
    begin
        logic [rrp_pkg::PROD_W-1:0] rnd;
        logic [rrp_pkg::PROD_W-1:0] mag;
        rnd = s2_prod_reg + rrp_pkg::PROD_W'(rrp_pkg::ROUND_HALF);
        mag = rnd >> rrp_pkg::FRAC_BITS;
        if (mag > rrp_pkg::PROD_W'(rrp_pkg::OUT_MAX))
        begin
            mag = rrp_pkg::PROD_W'(rrp_pkg::OUT_MAX);
        end
        if (s2_neg_reg)
        begin
            out_val_next = -$signed(mag[rrp_pkg::OUT_W-1:0]);
        end
        else
        begin
            out_val_next = $signed(mag[rrp_pkg::OUT_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (issue)
            begin
                row_reg <= pop ? '0 : row_reg + 1'b1;
            end
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_neg_reg  <= sel_acc[rrp_pkg::ACC_W-1];
            s1_mag_reg  <= sel_acc[rrp_pkg::ACC_W-1] ? rrp_pkg::ACC_W'(-sel_acc)
                                                     : rrp_pkg::ACC_W'(sel_acc);
            s1_row_reg  <= row_reg;
            s1_last_reg <= (row_reg == LAST_ROW);

            s2_prod_reg <= rrp_pkg::PROD_W'(s1_mag_reg) * rrp_pkg::PROD_W'(scale_q);
            s2_neg_reg  <= s1_neg_reg;
            s2_row_reg  <= s1_row_reg;
            s2_last_reg <= s1_last_reg;

            out_val_reg  <= out_val_next;
            out_idx_reg  <= rrp_pkg::IDX_W'(s2_row_reg);
            out_last_reg <= s2_last_reg;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.coord_index = out_idx_reg;
    assign result_ch.projected   = out_val_reg;
    assign result_ch.final_coord = out_last_reg;

endmodule

@@ sv/rademacher_random_projection.sv @@
// ============================================================================
// rademacher_random_projection
// Streamed random projection with a configurable sign matrix and Q1.15 scale.
// ============================================================================
// Throughput: one element per cycle while the queue has room; each vector
// yields OUT_DIM results, one per cycle unless the output stalls, from a back
// end fed by a two-entry queue of finished sums.
// Input stalls only while both queue slots hold vectors not yet popped.
// Reset clears accumulators, column position, queue and pipeline; the sign
// matrix resets to zero and the scale to 18919.
module rademacher_random_projection (
    input  logic                             clk,
    input  logic                             rst_n,
    rrp_in_if.sink                           sample_ch,
    rrp_out_if.source                        result_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rrp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rrp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    rrp_pkg::cfg_t     cfg;
    rrp_pkg::q_wr_t    q_wr;
    rrp_pkg::q_stat_t  q_stat;
    rrp_pkg::snap_t    head;
    logic              pop;

    rrp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .sign_bits (cfg.sign_bits),
        .q_stat    (q_stat),
        .q_wr      (q_wr)
    );

    rrp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .pop    (pop),
        .q_stat (q_stat),
        .head   (head)
    );

    rrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale_q   (cfg.scale_q),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule

@@ sv/rrp_checker.sv @@
// ============================================================================
// rrp_checker
// Port-level checks on the result stream of the projection block.
// ============================================================================
module rrp_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [rrp_pkg::IDX_W-1:0]         coord_index,
    input  logic signed [rrp_pkg::OUT_W-1:0]  projected,
    input  logic                              final_coord
);

    // A stalled word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coord_index)
                                    && $stable(projected) && $stable(final_coord))
        else $error("result word changed while stalled");

    // The scaled value never leaves its saturation range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (projected <= rrp_pkg::OUT_W'(rrp_pkg::OUT_MAX))
                   && (projected >= -rrp_pkg::OUT_W'(rrp_pkg::OUT_MAX)))
        else $error("projected value out of range");

    // The final coordinate of a vector carries the last index.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_coord |-> coord_index == rrp_pkg::IDX_W'(rrp_pkg::OUT_DIM - 1))
        else $error("final flag on wrong coordinate");

    // Coordinates of one vector follow each other without gaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_coord
            |=> out_valid && coord_index == $past(coord_index) + 1'b1)
        else $error("coordinate sequence broken");

endmodule

bind rademacher_random_projection rrp_checker u_rrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .coord_index (result_ch.coord_index),
    .projected   (result_ch.projected),
    .final_coord (result_ch.final_coord)
);
